>>> rtl/core/gftl_pkg.sv
// gftl_pkg: shared types and constants of the genotype fitness table lookup core
// request and response payloads, configuration view and register indices
// no dependencies
`timescale 1ns / 1ps

package gftl_pkg;

   localparam int unsigned TABLE_DEPTH = 243;
   localparam int unsigned TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int unsigned WT_REGS     = 4;

   // request actions
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_LOCUS = 1'b1;

   // ploidy modes (anything but haploid is treated as diploid)
   localparam logic [1:0] PLOIDY_HAPLOID = 2'd1;
   localparam logic [1:0] PLOIDY_DIPLOID = 2'd2;

   // configuration register indices
   localparam logic [2:0] CSR_PLOIDY     = 3'd0;
   localparam logic [2:0] CSR_WT_COUNT   = 3'd1;
   localparam logic [2:0] CSR_WILDTYPE_0 = 3'd2;
   localparam logic [2:0] CSR_WILDTYPE_1 = 3'd3;
   localparam logic [2:0] CSR_WILDTYPE_2 = 3'd4;
   localparam logic [2:0] CSR_WILDTYPE_3 = 3'd5;

   typedef struct packed {
      logic        action;
      logic [7:0]  table_address;
      logic [31:0] fitness_value;
      logic [7:0]  allele_first;
      logic [7:0]  allele_second;
      logic        last_locus;
   } req_type;

   typedef struct packed {
      logic [31:0] fitness;
      logic        too_many_loci;
   } rsp_type;

   typedef struct packed {
      logic [1:0]               ploidy_mode;
      logic [2:0]               wildtype_count;
      logic [WT_REGS-1:0][7:0]  wildtype;
   } cfg_type;

   // table read issued by the locus unit on the last locus of an individual
   typedef struct packed {
      logic       fire;
      logic [7:0] index;
      logic       too_many;
   } lkp_type;

endpackage

>>> rtl/core/gftl_ram.sv
// gftl_ram: generic single-write, single-read synchronous ram
// registered read data, read data holds when no read is issued
// no dependencies
`timescale 1ns / 1ps

module gftl_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 243
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/gftl_locus.sv
// gftl_locus: wildtype matching and mixed-radix genotype index accumulation
// issues the table lookup on the last locus of an individual
// depends on gftl_pkg
`timescale 1ns / 1ps

module gftl_locus #(
   parameter int unsigned MAX_LOCI       = 5,
   parameter int unsigned WILDTYPE_SLOTS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              locus_fire,
   input  gftl_pkg::req_type req,
   input  gftl_pkg::cfg_type cfg,
   output gftl_pkg::lkp_type lkp
);

   localparam int unsigned LOCI_W = $clog2(MAX_LOCI + 1);

   logic [7:0]        index_ff, index_in;
   logic [LOCI_W-1:0] loci_ff, loci_in;
   logic              ovf_ff, ovf_in;

   logic       match_a, match_b;
   logic       full;
   logic [7:0] next_index;
   logic [9:0] diploid_sum;
   logic [9:0] haploid_sum;
   logic [1:0] wt_n;

   always_comb begin
      match_a = 1'b0;
      match_b = 1'b0;
      for (int i = 0; i < gftl_pkg::WT_REGS; i++) begin
         if ((3'(i) < cfg.wildtype_count) && (i < WILDTYPE_SLOTS)) begin
            if (cfg.wildtype[i] == req.allele_first) begin
               match_a = 1'b1;
            end
            if (cfg.wildtype[i] == req.allele_second) begin
               match_b = 1'b1;
            end
         end
      end
   end

   assign wt_n        = {1'b0, match_a} + {1'b0, match_b};
   assign diploid_sum = 10'(index_ff) * 10'd3 + 10'd2 - 10'(wt_n);
   assign haploid_sum = {1'b0, index_ff, 1'b0} + 10'(!match_a);
   assign full        = (loci_ff >= LOCI_W'(MAX_LOCI));

   always_comb begin
      if (full) begin
         next_index = index_ff;
      end else if (cfg.ploidy_mode == gftl_pkg::PLOIDY_HAPLOID) begin
         next_index = haploid_sum[7:0];
      end else begin
         next_index = diploid_sum[7:0];
      end
   end

   always_comb begin
      index_in = index_ff;
      loci_in  = loci_ff;
      ovf_in   = ovf_ff;
      if (locus_fire) begin
         if (req.last_locus) begin
            index_in = '0;
            loci_in  = '0;
            ovf_in   = 1'b0;
         end else begin
            index_in = next_index;
            loci_in  = full ? loci_ff : loci_ff + LOCI_W'(1);
            ovf_in   = ovf_ff | full;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         loci_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         index_ff <= index_in;
         loci_ff  <= loci_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign lkp.fire     = locus_fire && req.last_locus;
   assign lkp.index    = next_index;
   assign lkp.too_many = ovf_ff | full;

endmodule

>>> rtl/core/genotype_fitness_table_lookup_core.sv
// genotype_fitness_table_lookup_core: top level of the fitness table lookup
// response: an accepted last-locus request reaches rsp_valid through the table read and the output register
// throughput: one request per cycle while req_stall is low, loads and loci alike
// lookup path: index update, table ram read, output register
// reset: synchronous, clears index state and pipeline valids, sets configuration to defaults
// fitness table is not cleared; entries must be written before being read (not enforced here)
`timescale 1ns / 1ps

module genotype_fitness_table_lookup_core #(
   parameter int unsigned MAX_LOCI       = 5,
   parameter int unsigned WILDTYPE_SLOTS = 4
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  gftl_pkg::req_type req_payload,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gftl_pkg::rsp_type rsp_payload,
   // configuration write channel
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_data
);

   // configuration registers
   gftl_pkg::cfg_type cfg_ff, cfg_in;

   // lookup stage: table read in flight
   logic s1_valid_ff, s1_valid_in;
   logic s1_ovf_ff, s1_ovf_in;
   logic s1_oob_ff, s1_oob_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   gftl_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic              req_fire;
   logic              locus_fire;
   logic              load_we;
   logic              s1_advance;
   logic              lkp_oob;
   logic [31:0]       table_rd;
   gftl_pkg::lkp_type lkp;

   // configuration writes, always accepted
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gftl_pkg::CSR_PLOIDY:     cfg_in.ploidy_mode    = csr_data[1:0];
            gftl_pkg::CSR_WT_COUNT:   cfg_in.wildtype_count = csr_data[2:0];
            gftl_pkg::CSR_WILDTYPE_0: cfg_in.wildtype[0]    = csr_data;
            gftl_pkg::CSR_WILDTYPE_1: cfg_in.wildtype[1]    = csr_data;
            gftl_pkg::CSR_WILDTYPE_2: cfg_in.wildtype[2]    = csr_data;
            gftl_pkg::CSR_WILDTYPE_3: cfg_in.wildtype[3]    = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ploidy_mode    <= gftl_pkg::PLOIDY_DIPLOID;
         cfg_ff.wildtype_count <= 3'd1;
         cfg_ff.wildtype       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // the lookup stage moves on whenever the output register is empty or drains;
   // requests are held off only while a finished lookup is stuck behind a
   // stalled response
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_fire   = req_valid && !req_stall;
   assign locus_fire = req_fire && (req_payload.action == gftl_pkg::ACTION_LOCUS);

   // loads beyond the table are dropped
   assign load_we = req_fire && (req_payload.action == gftl_pkg::ACTION_LOAD)
                    && (req_payload.table_address < 8'(gftl_pkg::TABLE_DEPTH));

   gftl_locus #(
      .MAX_LOCI       (MAX_LOCI),
      .WILDTYPE_SLOTS (WILDTYPE_SLOTS)
   ) u_locus (
      .clock      (clock),
      .reset      (reset),
      .locus_fire (locus_fire),
      .req        (req_payload),
      .cfg        (cfg_ff),
      .lkp        (lkp)
   );

   // an index past the table reads as zero and skips the ram
   assign lkp_oob = (lkp.index >= 8'(gftl_pkg::TABLE_DEPTH));

   // a load landing on the edge before a lookup of the same entry is already
   // in the array when the read happens, so no forwarding is needed
   gftl_ram #(
      .WIDTH (32),
      .DEPTH (gftl_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (gftl_pkg::TABLE_AW'(req_payload.table_address)),
      .wr_data (req_payload.fitness_value),
      .rd_en   (lkp.fire && !lkp_oob),
      .rd_addr (gftl_pkg::TABLE_AW'(lkp.index)),
      .rd_data (table_rd)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_ovf_in   = s1_ovf_ff;
      s1_oob_in   = s1_oob_ff;
      if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      if (lkp.fire) begin
         s1_valid_in = 1'b1;
         s1_ovf_in   = lkp.too_many;
         s1_oob_in   = lkp_oob;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_advance) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.fitness       = s1_oob_ff ? 32'd0 : table_rd;
         rsp_data_in.too_many_loci = s1_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ovf_ff   <= s1_ovf_in;
      s1_oob_ff   <= s1_oob_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

>>> rtl/core/gftl_checker.sv
// gftl_checker: port-level assertions for the fitness table lookup core
// bound to genotype_fitness_table_lookup_core; depends on gftl_pkg
`timescale 1ns / 1ps

module gftl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input gftl_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input gftl_pkg::rsp_type rsp_payload
);

   logic last_fire;

   assign last_fire = req_valid && !req_stall
                      && (req_payload.action == gftl_pkg::ACTION_LOCUS)
                      && req_payload.last_locus;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // requests are only held off behind a stalled response
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without downstream back-pressure");

   // a last locus on an empty output shows a response through the table read and the output register
   assert property (@(posedge clock) disable iff (reset)
      last_fire && !rsp_valid |=> ##1 rsp_valid)
      else $error("lookup response missing");

endmodule

bind genotype_fitness_table_lookup_core gftl_checker u_gftl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
